### rtl/core/lin_pkg.sv
// Shared types, constants and helpers of the 3x3 pivoting solver.
`default_nettype none
package lin_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int N                 = 3;

   // working system carried along the pipeline
   typedef struct packed {
      logic [N-1:0][N-1:0][31:0] m;
      logic [N-1:0][31:0]        r;
      logic [2:1][31:0]          x;
      logic                      sing;
   } sys_type;

   function automatic logic [32:0] mag(input logic [31:0] v);
      mag = v[31] ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
   endfunction

endpackage
`default_nettype wire

### rtl/core/linear_solve_3x3_pivoting.sv
// Top level: pipelined 3x3 solver, elimination with partial pivoting and back substitution.
//
// Request channel (req_*): one 3x3 system per accepted request, nine
// coefficients and three right-hand sides, signed with FRAC_BITS fraction bits.
// Result channel (rsp_*): the three unknowns, clamped to 32 bits, and a
// singular flag; on a zero pivot all unknowns read zero.
// Throughput: one request per cycle while req_ready is high. The pipeline is a chain
// of five bit-per-stage dividers (32+FRAC_BITS quotient-bit stages each, plus an
// input and an output register), five two-stage multiply-subtract units and three
// single registers. Column elimination runs in parallel lanes, one divider lane per
// row below the pivot.
// If the result register holds an untaken result and the last pipeline
// stage is occupied, the whole pipeline freezes and req_ready drops;
// bubbles still move up while the result waits.
// Synchronous reset empties every stage and the result register.
`default_nettype none
module linear_solve_3x3_pivoting #(
   parameter int FRAC_BITS = lin_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_a00,
   input  wire logic [31:0] req_a01,
   input  wire logic [31:0] req_a02,
   input  wire logic [31:0] req_a10,
   input  wire logic [31:0] req_a11,
   input  wire logic [31:0] req_a12,
   input  wire logic [31:0] req_a20,
   input  wire logic [31:0] req_a21,
   input  wire logic [31:0] req_a22,
   input  wire logic [31:0] req_rhs0,
   input  wire logic [31:0] req_rhs1,
   input  wire logic [31:0] req_rhs2,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_sol0,
   output logic [31:0]      rsp_sol1,
   output logic [31:0]      rsp_sol2,
   output logic             rsp_singular
);

   logic en;

   // ---- column 0 pivot ----
   lin_pkg::sys_type s_in, p0_in, p0_ff;
   logic             p0_valid_ff;
   logic [32:0]      bmag0;
   logic [1:0]       best0;

   always_comb begin
      s_in      = '0;
      s_in.m[0] = {req_a02, req_a01, req_a00};
      s_in.m[1] = {req_a12, req_a11, req_a10};
      s_in.m[2] = {req_a22, req_a21, req_a20};
      s_in.r    = {req_rhs2, req_rhs1, req_rhs0};
      best0 = 2'd0;
      bmag0 = lin_pkg::mag(s_in.m[0][0]);
      if (lin_pkg::mag(s_in.m[1][0]) > bmag0) begin
         best0 = 2'd1;
         bmag0 = lin_pkg::mag(s_in.m[1][0]);
      end
      if (lin_pkg::mag(s_in.m[2][0]) > bmag0) begin
         best0 = 2'd2;
      end
      p0_in = s_in;
      if (best0 == 2'd1) begin
         p0_in.m[0] = s_in.m[1];  p0_in.m[1] = s_in.m[0];
         p0_in.r[0] = s_in.r[1];  p0_in.r[1] = s_in.r[0];
      end else if (best0 == 2'd2) begin
         p0_in.m[0] = s_in.m[2];  p0_in.m[2] = s_in.m[0];
         p0_in.r[0] = s_in.r[2];  p0_in.r[2] = s_in.r[0];
      end
      p0_in.sing = (p0_in.m[0][0] == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= req_valid;
      end
      if (en) begin
         p0_ff <= p0_in;
      end
   end

   // ---- column 0 factors, one lane per lower row ----
   logic             d0_valid;
   lin_pkg::sys_type d0_side;
   logic [1:0][31:0] d0_q;

   lin_div #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_div0 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(p0_valid_ff), .in_side(p0_ff),
      .num({p0_ff.m[2][0], p0_ff.m[1][0]}), .den(p0_ff.m[0][0]),
      .out_valid(d0_valid), .out_side(d0_side), .quo(d0_q)
   );

   logic             m0_valid;
   lin_pkg::sys_type m0_side;
   logic [5:0][31:0] m0_res;

   lin_msub #(.FRAC_BITS(FRAC_BITS), .LANES(6)) u_msub0 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d0_valid), .in_side(d0_side),
      .a({d0_side.r[2], d0_side.m[2][2], d0_side.m[2][1],
          d0_side.r[1], d0_side.m[1][2], d0_side.m[1][1]}),
      .p({d0_q[1], d0_q[1], d0_q[1], d0_q[0], d0_q[0], d0_q[0]}),
      .q({d0_side.r[0], d0_side.m[0][2], d0_side.m[0][1],
          d0_side.r[0], d0_side.m[0][2], d0_side.m[0][1]}),
      .out_valid(m0_valid), .out_side(m0_side), .res(m0_res)
   );

   // ---- column 1 pivot ----
   lin_pkg::sys_type e0, p1_in, p1_ff;
   logic             p1_valid_ff;

   always_comb begin
      e0         = m0_side;
      e0.m[1][1] = m0_res[0];
      e0.m[1][2] = m0_res[1];
      e0.r[1]    = m0_res[2];
      e0.m[2][1] = m0_res[3];
      e0.m[2][2] = m0_res[4];
      e0.r[2]    = m0_res[5];
      p1_in = e0;
      // ties keep the upper row
      if (lin_pkg::mag(e0.m[2][1]) > lin_pkg::mag(e0.m[1][1])) begin
         p1_in.m[1] = e0.m[2];  p1_in.m[2] = e0.m[1];
         p1_in.r[1] = e0.r[2];  p1_in.r[2] = e0.r[1];
      end
      p1_in.sing = e0.sing | (p1_in.m[1][1] == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= m0_valid;
      end
      if (en) begin
         p1_ff <= p1_in;
      end
   end

   // ---- column 1 factor and update ----
   logic             d1_valid;
   lin_pkg::sys_type d1_side;
   logic [0:0][31:0] d1_q;

   lin_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div1 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(p1_valid_ff), .in_side(p1_ff),
      .num(p1_ff.m[2][1]), .den(p1_ff.m[1][1]),
      .out_valid(d1_valid), .out_side(d1_side), .quo(d1_q)
   );

   logic             m1_valid;
   lin_pkg::sys_type m1_side;
   logic [1:0][31:0] m1_res;

   lin_msub #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_msub1 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d1_valid), .in_side(d1_side),
      .a({d1_side.r[2], d1_side.m[2][2]}),
      .p({d1_q[0], d1_q[0]}),
      .q({d1_side.r[1], d1_side.m[1][2]}),
      .out_valid(m1_valid), .out_side(m1_side), .res(m1_res)
   );

   // ---- back substitution, x2 ----
   lin_pkg::sys_type e1;

   always_comb begin
      e1         = m1_side;
      e1.m[2][2] = m1_res[0];
      e1.r[2]    = m1_res[1];
      e1.sing    = m1_side.sing | (m1_res[0] == 32'd0);
   end

   logic             d2_valid;
   lin_pkg::sys_type d2_side, e2;
   logic [0:0][31:0] d2_q;

   lin_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div2 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(m1_valid), .in_side(e1),
      .num(e1.r[2]), .den(e1.m[2][2]),
      .out_valid(d2_valid), .out_side(d2_side), .quo(d2_q)
   );

   always_comb begin
      e2      = d2_side;
      e2.x[2] = d2_q[0];
   end

   // ---- x1 ----
   logic             m2_valid;
   lin_pkg::sys_type m2_side, e3;
   logic [0:0][31:0] m2_res;

   lin_msub #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_msub2 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d2_valid), .in_side(e2),
      .a(e2.r[1]), .p(e2.m[1][2]), .q(e2.x[2]),
      .out_valid(m2_valid), .out_side(m2_side), .res(m2_res)
   );

   always_comb begin
      e3      = m2_side;
      e3.r[1] = m2_res[0];
   end

   logic             d3_valid;
   lin_pkg::sys_type d3_side, e4;
   logic [0:0][31:0] d3_q;

   lin_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div3 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(m2_valid), .in_side(e3),
      .num(e3.r[1]), .den(e3.m[1][1]),
      .out_valid(d3_valid), .out_side(d3_side), .quo(d3_q)
   );

   always_comb begin
      e4      = d3_side;
      e4.x[1] = d3_q[0];
   end

   // ---- x0: two dependent subtractions then the divide ----
   logic             m3_valid;
   lin_pkg::sys_type m3_side, e5;
   logic [0:0][31:0] m3_res;

   lin_msub #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_msub3 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d3_valid), .in_side(e4),
      .a(e4.r[0]), .p(e4.m[0][1]), .q(e4.x[1]),
      .out_valid(m3_valid), .out_side(m3_side), .res(m3_res)
   );

   always_comb begin
      e5      = m3_side;
      e5.r[0] = m3_res[0];
   end

   logic             m4_valid;
   lin_pkg::sys_type m4_side, e6;
   logic [0:0][31:0] m4_res;

   lin_msub #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_msub4 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(m3_valid), .in_side(e5),
      .a(e5.r[0]), .p(e5.m[0][2]), .q(e5.x[2]),
      .out_valid(m4_valid), .out_side(m4_side), .res(m4_res)
   );

   always_comb begin
      e6      = m4_side;
      e6.r[0] = m4_res[0];
   end

   logic             d4_valid;
   lin_pkg::sys_type d4_side;
   logic [0:0][31:0] d4_q;

   lin_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div4 (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(m4_valid), .in_side(e6),
      .num(e6.r[0]), .den(e6.m[0][0]),
      .out_valid(d4_valid), .out_side(d4_side), .quo(d4_q)
   );

   // ---- result register ----
   logic        rsp_valid_ff;
   logic [31:0] sol0_ff, sol1_ff, sol2_ff;
   logic        sing_ff;

   assign en = !(d4_valid && rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && d4_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (en && d4_valid) begin
         sol0_ff <= d4_side.sing ? 32'd0 : d4_q[0];
         sol1_ff <= d4_side.sing ? 32'd0 : d4_side.x[1];
         sol2_ff <= d4_side.sing ? 32'd0 : d4_side.x[2];
         sing_ff <= d4_side.sing;
      end
   end

   assign req_ready    = en;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sol0     = sol0_ff;
   assign rsp_sol1     = sol1_ff;
   assign rsp_sol2     = sol2_ff;
   assign rsp_singular = sing_ff;

   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_sol0 == 32'd0 && rsp_sol1 == 32'd0
                                    && rsp_sol2 == 32'd0)
      else $error("singular result with nonzero unknowns");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled without a blocked result");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
`default_nettype wire

### rtl/core/lin_div.sv
// Pipelined signed scaled divider, one quotient bit per stage, several lanes.
`default_nettype none
module lin_div #(
   parameter int FRAC_BITS = lin_pkg::FRAC_BITS_DEFAULT,
   parameter int LANES     = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire lin_pkg::sys_type       in_side,
   input  wire logic [LANES-1:0][31:0] num,
   input  wire logic [31:0]            den,
   output logic                        out_valid,
   output lin_pkg::sys_type            out_side,
   output logic [LANES-1:0][31:0]      quo
);

   localparam int NB = 32 + FRAC_BITS;
   localparam logic [NB-1:0] LIM_POS = NB'(32'h7fff_ffff);
   localparam logic [NB-1:0] LIM_NEG = NB'(32'h8000_0000);

   logic                          valid_ff [0:NB];
   lin_pkg::sys_type              side_ff  [0:NB];
   logic [31:0]                   dmag_ff  [0:NB];
   logic [LANES-1:0]              neg_ff   [0:NB];
   logic [LANES-1:0][31:0]        rem_ff   [0:NB];
   logic [LANES-1:0][NB-1:0]      dq_ff    [0:NB];

   logic [LANES-1:0][31:0] nmag;
   logic [LANES-1:0][31:0] quo_in;
   logic                   out_valid_ff;
   lin_pkg::sys_type       out_side_ff;
   logic [LANES-1:0][31:0] quo_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         nmag[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         side_ff[0] <= in_side;
         dmag_ff[0] <= den[31] ? (~den + 32'd1) : den;
         for (int l = 0; l < LANES; l++) begin
            neg_ff[0][l] <= num[l][31] ^ den[31];
            rem_ff[0][l] <= '0;
            dq_ff[0][l]  <= {nmag[l], {FRAC_BITS{1'b0}}};
         end
      end
   end

   for (genvar s = 1; s <= NB; s++) begin : g_step
      logic [LANES-1:0][32:0] trial;
      logic [LANES-1:0][32:0] diff;
      logic [LANES-1:0]       ge;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_ff[s-1][l], dq_ff[s-1][l][NB-1]};
            diff[l]  = trial[l] - {1'b0, dmag_ff[s-1]};
            ge[l]    = trial[l] >= {1'b0, dmag_ff[s-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         if (en) begin
            side_ff[s] <= side_ff[s-1];
            dmag_ff[s] <= dmag_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= ge[l] ? diff[l][31:0] : trial[l][31:0];
               dq_ff[s][l]  <= {dq_ff[s-1][l][NB-2:0], ge[l]};
            end
         end
      end
   end

   // sign and clamp to 32 bits
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (neg_ff[NB][l]) begin
            quo_in[l] = (dq_ff[NB][l] > LIM_NEG) ? 32'h8000_0000
                                                 : (~dq_ff[NB][l][31:0] + 32'd1);
         end else begin
            quo_in[l] = (dq_ff[NB][l] > LIM_POS) ? 32'h7fff_ffff : dq_ff[NB][l][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[NB];
      end
      if (en) begin
         out_side_ff <= side_ff[NB];
         quo_ff      <= quo_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign quo       = quo_ff;

endmodule
`default_nettype wire

### rtl/core/lin_msub.sv
// Two-stage multiply, scale and subtract with saturation, several lanes.
`default_nettype none
module lin_msub #(
   parameter int FRAC_BITS = lin_pkg::FRAC_BITS_DEFAULT,
   parameter int LANES     = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire lin_pkg::sys_type       in_side,
   input  wire logic [LANES-1:0][31:0] a,
   input  wire logic [LANES-1:0][31:0] p,
   input  wire logic [LANES-1:0][31:0] q,
   output logic                        out_valid,
   output lin_pkg::sys_type            out_side,
   output logic [LANES-1:0][31:0]      res
);

   localparam logic signed [63:0] RND   = (64'sd1 <<< FRAC_BITS) - 64'sd1;
   localparam logic signed [63:0] S_MAX = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] S_MIN = -64'sh0000_0000_8000_0000;

   logic                   valid0_ff, valid1_ff;
   lin_pkg::sys_type       side0_ff, side1_ff;
   logic signed [63:0]     prod_ff [LANES];
   logic [LANES-1:0][31:0] a_ff;
   logic [LANES-1:0][31:0] res_in, res_ff;
   logic signed [63:0]     adj [LANES];
   logic signed [63:0]     diff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= in_valid;
         valid1_ff <= valid0_ff;
      end
      if (en) begin
         side0_ff <= in_side;
         side1_ff <= side0_ff;
         a_ff     <= a;
         res_ff   <= res_in;
         for (int l = 0; l < LANES; l++) begin
            prod_ff[l] <= $signed(p[l]) * $signed(q[l]);
         end
      end
   end

   // truncate toward zero, then subtract and clamp
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         adj[l]  = prod_ff[l][63] ? (prod_ff[l] + RND) : prod_ff[l];
         diff[l] = $signed({{32{a_ff[l][31]}}, a_ff[l]}) - (adj[l] >>> FRAC_BITS);
         if (diff[l] > S_MAX) begin
            res_in[l] = 32'h7fff_ffff;
         end else if (diff[l] < S_MIN) begin
            res_in[l] = 32'h8000_0000;
         end else begin
            res_in[l] = diff[l][31:0];
         end
      end
   end

   assign out_valid = valid1_ff;
   assign out_side  = side1_ff;
   assign res       = res_ff;

endmodule
`default_nettype wire
